// ===== rtl/core/button_tuned_led_pattern_sequencer_core_macros.svh =====
// Assertion macros for the LED pattern sequencer core.
// Included by the top level; define NO_ASSERTIONS to compile them out.
`ifndef BUTTON_TUNED_LED_PATTERN_SEQUENCER_CORE_MACROS_SVH
`define BUTTON_TUNED_LED_PATTERN_SEQUENCER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that cons holds in the same cycle as ante.
`define BLTS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Check that cons holds in the cycle after ante.
`define BLTS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define BLTS_ASSERT_SAME(label, clk, rstn, ante, cons)
`define BLTS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/blts_pkg.sv =====
// Shared types and constants of the LED pattern sequencer core.
// No dependencies; used by every module of the core but blts_fifo.
`default_nettype none

package blts_pkg;

    localparam int unsigned MODE_COUNT    = 3;
    localparam int unsigned LONG_INTERVAL = 200;

    localparam int unsigned PERIOD_W  = 16;
    localparam int unsigned ELAPSED_W = 17;
    localparam int unsigned THRESH_W  = 18;
    localparam int unsigned K_W       = 9;
    localparam int unsigned ACC_W     = 19;
    localparam int unsigned SUM_W     = 21;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam logic [PERIOD_W-1:0]  PRESS_MAX   = '1;
    localparam logic [PERIOD_W-1:0]  PERIOD_MAX  = '1;
    localparam logic [7:0]           DEBOUNCE_MAX = '1;
    localparam logic signed [SUM_W-1:0] SUM_ZERO    = '0;
    localparam logic signed [SUM_W-1:0] SUM_CEILING = SUM_W'(65535);

    // Divide a 16-bit count by LONG_INTERVAL: ((x >> 3) * DIV_MUL) >> DIV_SHIFT
    localparam logic [12:0] DIV_MUL   = 13'd5243;
    localparam int unsigned DIV_SHIFT = 17;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_LONG_THRESHOLD = 3'd0,
        CFG_DEBOUNCE       = 3'd1,
        CFG_PHASE_STEP     = 3'd2,
        CFG_PERIOD_STEP    = 3'd3,
        CFG_WRAP_PERIOD    = 3'd4,
        CFG_INITIAL_PERIOD = 3'd5
    } cfg_index_t;

    // Register values after reset
    localparam logic [15:0] RST_LONG_THRESHOLD = 16'd500;
    localparam logic [7:0]  RST_DEBOUNCE       = 8'd20;
    localparam logic [13:0] RST_PHASE_STEP     = 14'd300;
    localparam logic [9:0]  RST_PERIOD_STEP    = 10'd100;
    localparam logic [15:0] RST_WRAP_PERIOD    = 16'd2000;
    localparam logic [15:0] RST_INITIAL_PERIOD = 16'd500;

    // Effect modes
    localparam logic [1:0] MODE_FORWARD = 2'd0;
    localparam logic [1:0] MODE_REVERSE = 2'd1;
    localparam logic [1:0] MODE_ALL     = 2'd2;

    // LED masks: bit 0 red, bit 1 green, bit 2 blue
    localparam logic [2:0] LED_RED   = 3'b001;
    localparam logic [2:0] LED_GREEN = 3'b010;
    localparam logic [2:0] LED_BLUE  = 3'b100;
    localparam logic [2:0] LED_ALL   = 3'b111;

    typedef enum logic [1:0] {
        PRESS_IDLE     = 2'd0,
        PRESS_DEBOUNCE = 2'd1,
        PRESS_HELD     = 2'd2
    } press_phase_t;

    typedef enum logic [1:0] {
        SEQ_FIRST  = 2'd0,
        SEQ_SECOND = 2'd1,
        SEQ_THIRD  = 2'd2,
        SEQ_END    = 2'd3
    } seq_phase_t;

    // Classified input tick
    typedef struct packed {
        logic [1:0] level;  // bit 0 button one, bit 1 button two
        logic       any;    // some button is down
        logic       sel;    // button that would start a press (one wins)
    } item_t;

    // One result item
    typedef struct packed {
        logic [2:0]          leds;
        logic [1:0]          mode;
        logic [PERIOD_W-1:0] period;
        logic                busy;
    } result_t;

    // Status from the back end
    typedef struct packed {
        logic press_active;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/blts_fifo.sv =====
// Small register queue with valid/ready on both sides.
// Generic; used by the front end and for the result queue.
`default_nettype none

module blts_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [WIDTH-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry on a transfer in
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/blts_front.sv =====
// Front end: accepts button ticks, classifies them and queues them.
// Depends on blts_pkg and blts_fifo.
`default_nettype none

module blts_front #(
    parameter int DEPTH = 2
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic           s_button_one_pressed,
    input  wire logic           s_button_two_pressed,
    output logic                item_valid,
    input  wire logic           item_ready,
    output blts_pkg::item_t     item
);

    blts_pkg::item_t in_item;
    logic [$bits(blts_pkg::item_t)-1:0] out_bits;

    // Classify: any button down, and which one starts a press
    always_comb begin
        in_item.level = {s_button_two_pressed, s_button_one_pressed};
        in_item.any   = s_button_one_pressed | s_button_two_pressed;
        in_item.sel   = !s_button_one_pressed;
    end

    blts_fifo #(
        .WIDTH ($bits(blts_pkg::item_t)),
        .DEPTH (DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (in_item),
        .out_valid (item_valid),
        .out_ready (item_ready),
        .out_data  (out_bits)
    );

    assign item = blts_pkg::item_t'(out_bits);

endmodule

`default_nettype wire

// ===== rtl/core/blts_back.sv =====
// Back end: press qualification, period adjustment and LED pattern.
// Processes one queued tick per cycle while the result queue takes results. Depends on blts_pkg.
`default_nettype none

module blts_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [15:0]         cfg_wdata,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire blts_pkg::item_t     item,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output blts_pkg::result_t        res,
    output blts_pkg::status_t        status
);

    localparam int PW = blts_pkg::PERIOD_W;
    localparam int EW = blts_pkg::ELAPSED_W;
    localparam int TW = blts_pkg::THRESH_W;
    localparam int SW = blts_pkg::SUM_W;
    localparam int AW = blts_pkg::ACC_W;
    localparam int KW = blts_pkg::K_W;
    localparam int MC = blts_pkg::MODE_COUNT;

    localparam logic signed [SW-1:0] SUM_ZERO_L = blts_pkg::SUM_ZERO;

    // Configuration registers
    logic [15:0]   thresh_reg, thresh_next;
    logic [7:0]    debounce_cfg_reg, debounce_cfg_next;
    logic [13:0]   phase_step_reg, phase_step_next;
    logic [9:0]    period_step_reg, period_step_next;
    logic [PW-1:0] wrap_reg, wrap_next;
    logic [PW-1:0] initial_reg, initial_next;

    // Core state
    logic [PW-1:0] mode_periods_reg [MC];
    logic [PW-1:0] mode_periods_next [MC];
    logic [1:0]    mode_reg, mode_next;
    logic [PW-1:0] period_reg, period_next;
    logic [EW-1:0] elapsed_reg, elapsed_next;
    logic [PW-1:0] press_ticks_reg, press_ticks_next;
    logic [KW-1:0] k_reg, k_next;
    logic [2:0]    leds_reg, leds_next;
    logic [7:0]    debounce_reg, debounce_next;
    logic          button_reg, button_next;
    blts_pkg::seq_phase_t   seq_reg, seq_next;
    blts_pkg::press_phase_t press_reg, press_next;

    // Control
    logic          step;
    logic          btn_level;
    logic [7:0]    debounce_inc;
    logic [EW-1:0] elapsed_inc;
    logic          press_idle;
    logic          qualify;
    logic          release_now;
    logic          pattern_run;

    // Long-press interval count
    logic [PW-1:0] over;
    logic [25:0]   over_prod;
    logic [AW-1:0] acc;

    // Release arithmetic
    logic                 is_long;
    logic                 short_two;
    logic signed [SW-1:0] diff;
    logic [1:0]           mode_after;
    logic signed [SW-1:0] adj_sum [MC];
    logic [PW-1:0]        adj_period [MC];

    // Pattern evaluation
    logic [TW-1:0]  t0, t1, t2, t3, e_ext;
    logic [2:0]     pat_leds;
    logic [EW-1:0]  pat_elapsed;
    logic           pat_done;
    blts_pkg::seq_phase_t pat_seq;

    assign step         = item_valid & res_ready;
    assign item_ready   = res_ready;
    assign res_valid    = item_valid;
    assign btn_level    = item.level[button_reg];
    assign debounce_inc = (debounce_reg == blts_pkg::DEBOUNCE_MAX) ?
                          debounce_reg : debounce_reg + 1'b1;
    assign elapsed_inc  = (elapsed_reg == blts_pkg::ELAPSED_MAX) ?
                          elapsed_reg : elapsed_reg + 1'b1;
    assign press_idle   = (press_reg != blts_pkg::PRESS_DEBOUNCE) &&
                          (press_reg != blts_pkg::PRESS_HELD);

    // Press phase: next state
    always_comb begin
        press_next = press_reg;
        if (step) begin
            unique case (press_reg)
                blts_pkg::PRESS_DEBOUNCE: begin
                    if (!btn_level) begin
                        press_next = blts_pkg::PRESS_IDLE;
                    end else if (debounce_inc >= debounce_cfg_reg) begin
                        press_next = blts_pkg::PRESS_HELD;
                    end
                end
                blts_pkg::PRESS_HELD: begin
                    if (!btn_level) begin
                        press_next = blts_pkg::PRESS_IDLE;
                    end
                end
                default: begin
                    if (item.any) begin
                        press_next = (debounce_cfg_reg == '0) ? blts_pkg::PRESS_HELD :
                                                                blts_pkg::PRESS_DEBOUNCE;
                    end else begin
                        press_next = blts_pkg::PRESS_IDLE;
                    end
                end
            endcase
        end
    end

    // Press phase: decoded actions
    always_comb begin
        qualify     = step && (press_next == blts_pkg::PRESS_HELD) &&
                      (press_reg != blts_pkg::PRESS_HELD);
        release_now = step && (press_reg == blts_pkg::PRESS_HELD) && !btn_level;
        pattern_run = step && press_idle && (press_next == blts_pkg::PRESS_IDLE);
        status.press_active = !press_idle;
    end

    // Track whole long-press intervals of the next state; scale by the period step
    always_comb begin
        over      = (press_ticks_next >= thresh_next) ? press_ticks_next - thresh_next : '0;
        over_prod = {13'd0, over[PW-1:3]} * {13'd0, blts_pkg::DIV_MUL};
        k_next    = over_prod[blts_pkg::DIV_SHIFT +: KW];
        acc       = {{(AW-10){1'b0}}, period_step_reg} * {{(AW-KW){1'b0}}, k_reg};
    end

    // Release: pick the signed period change and the next mode
    always_comb begin
        is_long   = (press_ticks_reg >= thresh_reg);
        short_two = !is_long && button_reg;
        if (!is_long) begin
            diff = button_reg ? SUM_ZERO_L : -$signed({{(SW-10){1'b0}}, period_step_reg});
        end else begin
            diff = button_reg ? $signed({{(SW-AW){1'b0}}, acc}) :
                                -$signed({{(SW-AW){1'b0}}, acc});
        end
        if (short_two) begin
            mode_after = (mode_reg == blts_pkg::MODE_ALL) ? blts_pkg::MODE_FORWARD :
                                                            mode_reg + 1'b1;
        end else begin
            mode_after = mode_reg;
        end
    end

    // Apply the change to every mode period; wrap at zero, saturate on top
    always_comb begin
        for (int i = 0; i < MC; i++) begin
            adj_sum[i] = $signed({{(SW-PW){1'b0}}, mode_periods_reg[i]}) + diff;
            if (adj_sum[i] <= blts_pkg::SUM_ZERO) begin
                adj_period[i] = wrap_reg;
            end else if (adj_sum[i] > blts_pkg::SUM_CEILING) begin
                adj_period[i] = blts_pkg::PERIOD_MAX;
            end else begin
                adj_period[i] = adj_sum[i][PW-1:0];
            end
        end
    end

    // Pattern: do every toggle whose time has passed
    always_comb begin
        t0    = {2'b00, period_reg};
        t1    = {2'b00, period_reg} + {4'b0000, phase_step_reg};
        t2    = {2'b00, period_reg} + {3'b000, phase_step_reg, 1'b0};
        t3    = {2'b00, period_reg} + {4'b0000, phase_step_reg}
              + {3'b000, phase_step_reg, 1'b0};
        e_ext = {1'b0, elapsed_inc};
        pat_leds    = leds_reg;
        pat_seq     = seq_reg;
        pat_elapsed = elapsed_inc;
        pat_done    = 1'b0;
        for (int g = 0; g < 4; g++) begin
            if (!pat_done) begin
                unique case (pat_seq)
                    blts_pkg::SEQ_FIRST: begin
                        if (e_ext < t0) begin
                            pat_done = 1'b1;
                        end else if (mode_reg == blts_pkg::MODE_ALL) begin
                            pat_leds    = pat_leds ^ blts_pkg::LED_ALL;
                            pat_elapsed = '0;
                            pat_done    = 1'b1;
                        end else begin
                            pat_leds = pat_leds ^ ((mode_reg == blts_pkg::MODE_FORWARD) ?
                                                   blts_pkg::LED_RED : blts_pkg::LED_BLUE);
                            pat_seq  = blts_pkg::SEQ_SECOND;
                        end
                    end
                    blts_pkg::SEQ_SECOND: begin
                        if (e_ext < t1) begin
                            pat_done = 1'b1;
                        end else begin
                            pat_leds = pat_leds ^ blts_pkg::LED_GREEN;
                            pat_seq  = blts_pkg::SEQ_THIRD;
                        end
                    end
                    blts_pkg::SEQ_THIRD: begin
                        if (e_ext < t2) begin
                            pat_done = 1'b1;
                        end else begin
                            pat_leds = pat_leds ^ ((mode_reg == blts_pkg::MODE_FORWARD) ?
                                                   blts_pkg::LED_BLUE : blts_pkg::LED_RED);
                            pat_seq  = blts_pkg::SEQ_END;
                        end
                    end
                    default: begin
                        if (e_ext >= t3) begin
                            pat_elapsed = '0;
                            pat_seq     = blts_pkg::SEQ_FIRST;
                        end
                        pat_done = 1'b1;
                    end
                endcase
            end
        end
    end

    // Datapath next values
    always_comb begin
        thresh_next       = thresh_reg;
        debounce_cfg_next = debounce_cfg_reg;
        phase_step_next   = phase_step_reg;
        period_step_next  = period_step_reg;
        wrap_next         = wrap_reg;
        initial_next      = initial_reg;
        mode_periods_next = mode_periods_reg;
        mode_next         = mode_reg;
        period_next       = period_reg;
        elapsed_next      = elapsed_reg;
        press_ticks_next  = press_ticks_reg;
        leds_next         = leds_reg;
        debounce_next     = debounce_reg;
        button_next       = button_reg;
        seq_next          = seq_reg;

        if (step) begin
            elapsed_next = elapsed_inc;
            unique case (press_reg)
                blts_pkg::PRESS_DEBOUNCE: begin
                    debounce_next = btn_level ? debounce_inc : '0;
                end
                blts_pkg::PRESS_HELD: begin
                    if (btn_level && (press_ticks_reg != blts_pkg::PRESS_MAX)) begin
                        press_ticks_next = press_ticks_reg + 1'b1;
                    end
                end
                default: begin
                    if (item.any) begin
                        button_next   = item.sel;
                        debounce_next = '0;
                    end
                end
            endcase

            if (release_now) begin
                if (short_two) begin
                    leds_next = blts_pkg::LED_ALL;
                end
                mode_periods_next = adj_period;
                mode_next         = mode_after;
                period_next       = adj_period[mode_after];
            end

            if (qualify) begin
                press_ticks_next = '0;
                seq_next         = blts_pkg::SEQ_FIRST;
            end

            if (pattern_run) begin
                leds_next    = pat_leds;
                seq_next     = pat_seq;
                elapsed_next = pat_elapsed;
            end
        end

        // Configuration writes
        if (cfg_we) begin
            unique case (cfg_index)
                blts_pkg::CFG_LONG_THRESHOLD: thresh_next       = cfg_wdata;
                blts_pkg::CFG_DEBOUNCE:       debounce_cfg_next = cfg_wdata[7:0];
                blts_pkg::CFG_PHASE_STEP:     phase_step_next   = cfg_wdata[13:0];
                blts_pkg::CFG_PERIOD_STEP:    period_step_next  = cfg_wdata[9:0];
                blts_pkg::CFG_WRAP_PERIOD:    wrap_next         = cfg_wdata;
                blts_pkg::CFG_INITIAL_PERIOD: begin
                    initial_next = cfg_wdata;
                    for (int i = 0; i < MC; i++) begin
                        mode_periods_next[i] = cfg_wdata;
                    end
                    period_next = cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Result of this tick
    always_comb begin
        res.leds   = leds_next;
        res.mode   = mode_next;
        res.period = period_next;
        res.busy   = (press_next != blts_pkg::PRESS_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg       <= blts_pkg::RST_LONG_THRESHOLD;
            debounce_cfg_reg <= blts_pkg::RST_DEBOUNCE;
            phase_step_reg   <= blts_pkg::RST_PHASE_STEP;
            period_step_reg  <= blts_pkg::RST_PERIOD_STEP;
            wrap_reg         <= blts_pkg::RST_WRAP_PERIOD;
            initial_reg      <= blts_pkg::RST_INITIAL_PERIOD;
            for (int i = 0; i < MC; i++) begin
                mode_periods_reg[i] <= blts_pkg::RST_INITIAL_PERIOD;
            end
            mode_reg        <= blts_pkg::MODE_FORWARD;
            period_reg      <= blts_pkg::RST_INITIAL_PERIOD;
            elapsed_reg     <= '0;
            press_ticks_reg <= '0;
            k_reg           <= '0;
            leds_reg        <= '0;
            debounce_reg    <= '0;
            button_reg      <= 1'b0;
            seq_reg         <= blts_pkg::SEQ_FIRST;
            press_reg       <= blts_pkg::PRESS_IDLE;
        end else begin
            thresh_reg       <= thresh_next;
            debounce_cfg_reg <= debounce_cfg_next;
            phase_step_reg   <= phase_step_next;
            period_step_reg  <= period_step_next;
            wrap_reg         <= wrap_next;
            initial_reg      <= initial_next;
            mode_periods_reg <= mode_periods_next;
            mode_reg         <= mode_next;
            period_reg       <= period_next;
            elapsed_reg      <= elapsed_next;
            press_ticks_reg  <= press_ticks_next;
            k_reg            <= k_next;
            leds_reg         <= leds_next;
            debounce_reg     <= debounce_next;
            button_reg       <= button_next;
            seq_reg          <= seq_next;
            press_reg        <= press_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/button_tuned_led_pattern_sequencer_core.sv =====
// Button-tuned LED pattern sequencer: one input item is one millisecond tick with the two
// button levels, and each tick gives exactly one result (LED levels, mode, period, busy).
// The block sustains one tick per clock cycle unless m_ready stalls it; the back end
// finishes a whole tick, with press qualification, period adjustment and every due
// pattern toggle, in the cycle it takes the tick. Ticks pass the input queue, results the
// result queue; each queue holds QUEUE_DEPTH items, so either side may stall alone.
// The configuration port writes a register in the cycle cfg_we is high; the initial
// period also reloads all mode periods. Write only while no tick is in flight.
`default_nettype none

`include "button_tuned_led_pattern_sequencer_core_macros.svh"

module button_tuned_led_pattern_sequencer_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_button_one_pressed,
    input  wire logic        s_button_two_pressed,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_led_red,
    output logic             m_led_green,
    output logic             m_led_blue,
    output logic [1:0]       m_blink_mode,
    output logic [15:0]      m_blink_period,
    output logic             m_button_busy
);

    logic                item_valid;
    logic                item_ready;
    blts_pkg::item_t     item;
    logic                res_valid;
    logic                res_ready;
    blts_pkg::result_t   res;
    blts_pkg::status_t   status;
    logic [$bits(blts_pkg::result_t)-1:0] out_bits;
    blts_pkg::result_t   out_res;

    // Accept and classify ticks
    blts_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_button_one_pressed (s_button_one_pressed),
        .s_button_two_pressed (s_button_two_pressed),
        .item_valid           (item_valid),
        .item_ready           (item_ready),
        .item                 (item)
    );

    // Run the sequencer
    blts_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .status     (status)
    );

    // Hold results until the consumer takes the transfer
    blts_fifo #(
        .WIDTH ($bits(blts_pkg::result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_data   (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_bits)
    );

    assign out_res        = blts_pkg::result_t'(out_bits);
    assign m_led_red      = out_res.leds[0];
    assign m_led_green    = out_res.leds[1];
    assign m_led_blue     = out_res.leds[2];
    assign m_blink_mode   = out_res.mode;
    assign m_blink_period = out_res.period;
    assign m_button_busy  = out_res.busy;

    // A press seen while idle must start debounce or hold
    `BLTS_ASSERT_NEXT(a_press_starts, aclk, aresetn, item_valid && item_ready && !status.press_active && item.any, status.press_active)
    // No button while idle keeps the press logic idle
    `BLTS_ASSERT_NEXT(a_idle_stays, aclk, aresetn, item_valid && item_ready && !status.press_active && !item.any, !status.press_active)
    // Mode never leaves its range
    `BLTS_ASSERT_SAME(a_mode_range, aclk, aresetn, m_valid, m_blink_mode <= blts_pkg::MODE_ALL)

endmodule

`default_nettype wire

// ===== tb/sv/led_sequencer_checker.sv =====
// Checker for the button-tuned LED pattern sequencer core: tracks register writes and
// tick transfers, predicts each tick's LED/mode/period/busy result and compares it.
// Depends on blts_pkg for the register indexes, phase encodings and the result layout.
module led_sequencer_checker
    import blts_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_button_one_pressed,
    input  wire logic        s_button_two_pressed,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic        m_led_red,
    input  wire logic        m_led_green,
    input  wire logic        m_led_blue,
    input  wire logic [1:0]  m_blink_mode,
    input  wire logic [15:0] m_blink_period,
    input  wire logic        m_button_busy,
    output int               mismatch_total,
    output int               pending_ticks
);

    // Register copies
    logic [15:0] thr_reg;
    logic [7:0]  deb_reg;
    logic [13:0] phase_reg;
    logic [9:0]  pstep_reg;
    logic [15:0] wrap_reg;
    logic [15:0] init_reg;

    // Predicted core state
    logic [15:0]  period_tbl [MODE_COUNT];
    logic [1:0]   mode;
    logic [15:0]  cur_period;
    logic [16:0]  elapsed;
    logic [15:0]  held;
    seq_phase_t   seq;
    logic [2:0]   leds;
    logic [7:0]   deb_cnt;
    press_phase_t pphase;
    logic         btn;

    result_t due_outputs [$];
    int      errors = 0;

    function automatic void load_periods(input logic [15:0] v);
        int i;
        for (i = 0; i < MODE_COUNT; i++) begin
            period_tbl[i] = v;
        end
        cur_period = v;
    endfunction

    function automatic void reset_model();
        thr_reg   = RST_LONG_THRESHOLD;
        deb_reg   = RST_DEBOUNCE;
        phase_reg = RST_PHASE_STEP;
        pstep_reg = RST_PERIOD_STEP;
        wrap_reg  = RST_WRAP_PERIOD;
        init_reg  = RST_INITIAL_PERIOD;
        load_periods(RST_INITIAL_PERIOD);
        mode    = MODE_FORWARD;
        elapsed = '0;
        held    = '0;
        seq     = SEQ_FIRST;
        leds    = '0;
        deb_cnt = '0;
        pphase  = PRESS_IDLE;
        btn     = 1'b0;
    endfunction

    function automatic void write_register(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            CFG_LONG_THRESHOLD: thr_reg   = data;
            CFG_DEBOUNCE:       deb_reg   = data[7:0];
            CFG_PHASE_STEP:     phase_reg = data[13:0];
            CFG_PERIOD_STEP:    pstep_reg = data[9:0];
            CFG_WRAP_PERIOD:    wrap_reg  = data;
            CFG_INITIAL_PERIOD: begin
                init_reg = data;
                load_periods(data);
            end
            default: ;
        endcase
    endfunction

    // Qualified press: start timing and abort the running pattern
    function automatic void start_hold();
        pphase = PRESS_HELD;
        held   = '0;
        seq    = SEQ_FIRST;
    endfunction

    // Act on a release: short or long press, then clamp every mode period
    function automatic void finish_press();
        int diff;
        int k;
        int p;
        int i;
        diff = 0;
        if (held < thr_reg) begin
            if (btn == 1'b0) begin
                diff = -int'(pstep_reg);
            end else begin
                leds = LED_ALL;
                mode = (mode == MODE_ALL) ? MODE_FORWARD : mode + 2'd1;
            end
        end else begin
            k    = (int'(held) - int'(thr_reg)) / int'(LONG_INTERVAL);
            diff = int'(pstep_reg) * k;
            if (btn == 1'b0) diff = -diff;
        end
        for (i = 0; i < MODE_COUNT; i++) begin
            p = int'(period_tbl[i]) + diff;
            if (p <= 0) p = int'(wrap_reg);
            else if (p > int'(PERIOD_MAX)) p = int'(PERIOD_MAX);
            period_tbl[i] = p[15:0];
        end
        cur_period = period_tbl[mode];
    endfunction

    // Advance the LED pattern through every toggle that is already due
    function automatic void run_pattern();
        int base;
        int step;
        int g;
        base = int'(cur_period);
        step = int'(phase_reg);
        for (g = 0; g < 4; g++) begin
            case (seq)
                SEQ_FIRST: begin
                    if (int'(elapsed) < base) return;
                    if (mode == MODE_ALL) begin
                        leds    = leds ^ LED_ALL;
                        elapsed = '0;
                        return;
                    end
                    leds = leds ^ ((mode == MODE_FORWARD) ? LED_RED : LED_BLUE);
                    seq  = SEQ_SECOND;
                end
                SEQ_SECOND: begin
                    if (int'(elapsed) < base + step) return;
                    leds = leds ^ LED_GREEN;
                    seq  = SEQ_THIRD;
                end
                SEQ_THIRD: begin
                    if (int'(elapsed) < base + 2 * step) return;
                    leds = leds ^ ((mode == MODE_FORWARD) ? LED_BLUE : LED_RED);
                    seq  = SEQ_END;
                end
                default: begin
                    if (int'(elapsed) < base + 3 * step) return;
                    elapsed = '0;
                    seq     = SEQ_FIRST;
                    return;
                end
            endcase
        end
    endfunction

    // One millisecond tick: count, run the button logic, then the pattern
    function automatic result_t advance_tick(input logic b1, input logic b2);
        logic [1:0] lvl;
        logic       was_idle;
        result_t    r;
        lvl      = {b2, b1};
        was_idle = (pphase == PRESS_IDLE);
        if (elapsed != ELAPSED_MAX) elapsed = elapsed + 17'd1;
        case (pphase)
            PRESS_IDLE: begin
                if (b1 || b2) begin
                    btn     = b1 ? 1'b0 : 1'b1;
                    deb_cnt = '0;
                    if (deb_reg == 8'd0) start_hold();
                    else pphase = PRESS_DEBOUNCE;
                end
            end
            PRESS_DEBOUNCE: begin
                if (!lvl[btn]) begin
                    pphase  = PRESS_IDLE;
                    deb_cnt = '0;
                end else begin
                    if (deb_cnt != DEBOUNCE_MAX) deb_cnt = deb_cnt + 8'd1;
                    if (deb_cnt >= deb_reg) start_hold();
                end
            end
            default: begin
                if (lvl[btn]) begin
                    if (held != PRESS_MAX) held = held + 16'd1;
                end else begin
                    finish_press();
                    pphase = PRESS_IDLE;
                end
            end
        endcase
        if (was_idle && pphase == PRESS_IDLE) run_pattern();
        r.leds   = leds;
        r.mode   = mode;
        r.period = cur_period;
        r.busy   = (pphase != PRESS_IDLE);
        return r;
    endfunction

    // Track writes and ticks, compare each result transfer with the oldest prediction
    always @(posedge aclk) begin : monitor
        result_t want;
        result_t got;
        if (!aresetn) begin
            reset_model();
            due_outputs.delete();
        end else begin
            if (cfg_we) write_register(cfg_index, cfg_wdata);
            if (s_valid && s_ready) begin
                due_outputs.push_back(advance_tick(s_button_one_pressed,
                                                   s_button_two_pressed));
            end
            if (m_valid && m_ready) begin
                got = {m_led_blue, m_led_green, m_led_red, m_blink_mode,
                       m_blink_period, m_button_busy};
                if (due_outputs.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result transfer at %0t", $time);
                end else begin
                    want = due_outputs.pop_front();
                    if (got.leds !== want.leds || got.mode !== want.mode ||
                        got.period !== want.period || got.busy !== want.busy) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch at %0t: leds(bgr) exp %b got %b, mode exp %0d got %0d, period exp %0d got %0d, busy exp %b got %b",
                                     $time, want.leds, got.leds, want.mode, got.mode,
                                     want.period, got.period, want.busy, got.busy);
                        end
                    end
                end
            end
        end
        pending_ticks  <= due_outputs.size();
        mismatch_total <= errors;
    end

endmodule

// ===== tb/sv/button_tuned_led_pattern_sequencer_core_tb.sv =====
// Top of the LED pattern sequencer testbench: clock, reset, register writes, button
// tick stimulus and result back-pressure. Needs the core, blts_pkg and led_sequencer_checker.
module button_tuned_led_pattern_sequencer_core_tb;
    import blts_pkg::*;

    localparam int         IDLE_LIMIT       = 2000;
    localparam logic [2:0] CFG_UNUSED_INDEX = 3'd7;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic        s_b1      = 1'b0;
    logic        s_b2      = 1'b0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic        m_led_red;
    logic        m_led_green;
    logic        m_led_blue;
    logic [1:0]  m_blink_mode;
    logic [15:0] m_blink_period;
    logic        m_button_busy;

    int mismatch_total;
    int pending_ticks;

    // Stimulus knobs; no_idle is shared by the sender and the receiver
    bit no_idle    = 1'b0;
    int ticks_sent = 0;
    int cur_thr    = RST_LONG_THRESHOLD;
    int cur_deb    = RST_DEBOUNCE;

    button_tuned_led_pattern_sequencer_core u_top (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_button_one_pressed (s_b1),
        .s_button_two_pressed (s_b2),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_led_red            (m_led_red),
        .m_led_green          (m_led_green),
        .m_led_blue           (m_led_blue),
        .m_blink_mode         (m_blink_mode),
        .m_blink_period       (m_blink_period),
        .m_button_busy        (m_button_busy)
    );

    led_sequencer_checker u_check (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_button_one_pressed (s_b1),
        .s_button_two_pressed (s_b2),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_led_red            (m_led_red),
        .m_led_green          (m_led_green),
        .m_led_blue           (m_led_blue),
        .m_blink_mode         (m_blink_mode),
        .m_blink_period       (m_blink_period),
        .m_button_busy        (m_button_busy),
        .mismatch_total       (mismatch_total),
        .pending_ticks        (pending_ticks)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Send one tick: optional gap, then hold valid until the transfer
    task automatic send_tick(input logic b1, input logic b2);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_b1    <= b1;
        s_b2    <= b2;
        do @(posedge aclk); while (!s_ready);
        ticks_sent++;
    endtask

    task automatic release_for(input int n);
        repeat (n) send_tick(1'b0, 1'b0);
    endtask

    // Hold a press: 0 button one, 1 button two, 2 both at once; the other button
    // chatters once the press has started
    task automatic hold_press(input int which, input int n);
        int i;
        for (i = 0; i < n; i++) begin
            case (which)
                0:       send_tick(1'b1, (i > 0) ? 1'($urandom_range(0, 1)) : 1'b0);
                1:       send_tick((i > 0) ? 1'($urandom_range(0, 1)) : 1'b0, 1'b1);
                default: send_tick(1'b1, (i > 0) ? 1'($urandom_range(0, 1)) : 1'b1);
            endcase
        end
    endtask

    // Stop sending and hold off until every predicted result has arrived
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_ticks != 0);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [15:0] thr, input logic [7:0] deb,
                                  input logic [13:0] phase, input logic [9:0] pstep,
                                  input logic [15:0] wrap, input logic [15:0] init);
        drain();
        cfg_write(CFG_LONG_THRESHOLD, thr);
        cfg_write(CFG_DEBOUNCE, 16'(deb));
        cfg_write(CFG_PHASE_STEP, 16'(phase));
        cfg_write(CFG_PERIOD_STEP, 16'(pstep));
        cfg_write(CFG_WRAP_PERIOD, wrap);
        cfg_write(CFG_INITIAL_PERIOD, init);
        cur_thr = thr;
        cur_deb = deb;
    endtask

    // Mostly clean presses with random length, plus bounces and raw noise
    task automatic random_sequence();
        int kind;
        int len;
        int cap;
        no_idle = ($urandom_range(0, 3) == 0);
        kind    = $urandom_range(0, 9);
        if (kind <= 6) begin
            cap = (cur_thr > 60) ? 60 : cur_thr;
            if (cur_thr <= 120 && $urandom_range(0, 2) == 0) begin
                len = cur_deb + 1 + cur_thr + $urandom_range(0, 410);
            end else begin
                len = cur_deb + 1 + $urandom_range(0, cap);
            end
            hold_press($urandom_range(0, 2), len);
            release_for($urandom_range(1, 40));
        end else if (kind == 7) begin
            // release before the press qualifies
            if (cur_deb > 0) hold_press($urandom_range(0, 1), $urandom_range(1, cur_deb));
            release_for($urandom_range(1, 5));
        end else begin
            repeat ($urandom_range(1, 10)) begin
                send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Result side: random stalls per result, none while no_idle is set
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // End the run when nothing has been transferred for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || cfg_we || (s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int ph;
        int phase_start;
        bit paused;
        logic [15:0] thr_v;
        logic [7:0]  deb_v;
        logic [13:0] phase_v;
        logic [9:0]  pstep_v;
        logic [15:0] wrap_v;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Defaults: bounce during debounce, both buttons at once, button two alone
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);

        // Zero debounce, tiny periods, largest period step; ignored register index
        apply_settings(16'd2, 8'd0, 14'd1, 10'd1023, 16'd1, 16'd1);
        cfg_write(CFG_UNUSED_INDEX, 16'hffff);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        hold_press(1, 2);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
        release_for(4);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        release_for(3);

        // Longest debounce, then a hold just past one long-press interval;
        // the raise then clips every period at the top
        apply_settings(16'd1, 8'd255, 14'd16383, 10'd1023, 16'hffff, 16'hffff);
        no_idle = 1'b1;
        hold_press(1, 256 + 205);
        release_for(3);
        no_idle = 1'b0;

        // Random phases, each with fresh settings and one full drain midway
        for (ph = 0; ph < 6; ph++) begin
            thr_v   = (ph == 2) ? 16'hffff : 16'($urandom_range(1, 120));
            deb_v   = (ph == 4) ? 8'd0 : 8'($urandom_range(0, 6));
            phase_v = (ph == 3) ? 14'd1 : 14'($urandom_range(1, 30));
            pstep_v = (ph % 2 == 1) ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(0, 40));
            wrap_v  = (ph == 1) ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 200));
            apply_settings(thr_v, deb_v, phase_v, pstep_v, wrap_v,
                           16'($urandom_range(1, 150)));
            phase_start = ticks_sent;
            paused      = 1'b0;
            while (ticks_sent - phase_start < 60) begin
                if (!paused && ticks_sent - phase_start >= 30) begin
                    drain();
                    paused = 1'b1;
                end
                random_sequence();
            end
        end

        // Let the last results out, then give the verdict
        no_idle = 1'b0;
        drain();
        repeat (10) @(posedge aclk);
        if (mismatch_total == 0 && pending_ticks == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== button_tuned_led_pattern_sequencer_core.f =====
+incdir+rtl/core
rtl/core/blts_pkg.sv
rtl/core/blts_fifo.sv
rtl/core/blts_front.sv
rtl/core/blts_back.sv
rtl/core/button_tuned_led_pattern_sequencer_core.sv
tb/sv/led_sequencer_checker.sv
tb/sv/button_tuned_led_pattern_sequencer_core_tb.sv
